// File: design/sparse_set_membership_table_macros.svh
// Assertion macros used by the sparse set membership table module.
`ifndef SPARSE_SET_MEMBERSHIP_TABLE_MACROS_SVH
`define SPARSE_SET_MEMBERSHIP_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define SSMT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define SSMT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ssmt_pkg.sv
// Types and codes of the sparse set membership table.
package ssmt_pkg;

   localparam int ID_W     = 10;
   localparam int SLOT_W   = 10;
   localparam int COUNT_W  = 11;

   typedef logic [1:0]         op_type;
   typedef logic [1:0]         status_type;
   typedef logic [ID_W-1:0]    id_type;
   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_LOOKUP = 2'd1;
   localparam op_type OP_REMOVE = 2'd2;

   localparam status_type ST_NEW     = 2'd0;
   localparam status_type ST_FOUND   = 2'd1;
   localparam status_type ST_ABSENT  = 2'd2;
   localparam status_type ST_REMOVED = 2'd3;

endpackage

// File: design/ssmt_req_if.sv
// Request channel: operation and id, with valid and ready.
interface ssmt_req_if;
   import ssmt_pkg::*;

   logic   valid;
   logic   ready;
   op_type op;
   id_type entity_id;

   modport source (output valid, output op, output entity_id, input ready);
   modport sink   (input valid, input op, input entity_id, output ready);

endinterface

// File: design/ssmt_rsp_if.sv
// Response channel: status, slot and live count, with valid and ready.
interface ssmt_rsp_if;
   import ssmt_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   slot_type   slot_index;
   count_type  live_count;

   modport source (output valid, output status, output slot_index, output live_count,
                   input ready);
   modport sink   (input valid, input status, input slot_index, input live_count,
                   output ready);

endinterface

// File: design/sparse_set_membership_table.sv
// Sparse set with swap-remove, kept in a sparse map memory and a dense id memory.
//
//   channel | direction | words carried
//   --------+-----------+-------------------------------------------
//   req     | in        | op, entity_id
//   rsp     | out       | status, slot_index, live_count
//
// A request reads both memories when it is taken, then decides and writes back.
// A remove that moves the last dense entry adds an unlink step, as the sparse map has one write port.
// After reset the sparse map is swept clear, one entry a cycle, from entry 0 to ID_SPACE-1,
// and no request is taken meanwhile.
// The response sits in an output register; a stalled response holds the decide step.
`include "sparse_set_membership_table_macros.svh"

module sparse_set_membership_table #(
   parameter int ID_SPACE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   ssmt_req_if.sink    req,
   ssmt_rsp_if.source  rsp
);
   import ssmt_pkg::*;

   localparam int IDX_W  = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
   localparam int CNT_W  = $clog2(ID_SPACE + 1);
   localparam int WIDE_W = (IDX_W > ID_W) ? IDX_W : ID_W;

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;
   localparam logic [1:0] S_UNLINK = 2'd3;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] slot;
   } sparse_entry_type;

   sparse_entry_type sparse_mem [ID_SPACE];
   logic [IDX_W-1:0] dense_mem  [ID_SPACE];

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clear_addr_ff, clear_addr_in;
   logic [CNT_W-1:0] live_total_ff, live_total_in;
   op_type           op_ff;
   logic [IDX_W-1:0] id_idx_ff;
   logic             in_range_ff;
   sparse_entry_type sp_rd_ff;
   logic [IDX_W-1:0] dn_rd_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   slot_type         rsp_slot_ff, rsp_slot_in;
   count_type        rsp_count_ff;

   logic             accept;
   logic             rsp_free;
   logic             rsp_load;
   logic [WIDE_W-1:0] id_wide;
   logic             id_in_range;

   logic             sp_we, sp_re;
   logic [IDX_W-1:0] sp_addr;
   sparse_entry_type sp_wdata;
   logic             dn_we, dn_re;
   logic [IDX_W-1:0] dn_addr;
   logic [IDX_W-1:0] dn_wdata;

   logic [IDX_W-1:0] last_slot;
   logic             full;
   logic             present;

   assign accept      = req.valid && req.ready;
   assign rsp_free    = !rsp_valid_ff || rsp.ready;
   assign id_wide     = WIDE_W'(req.entity_id);
   assign id_in_range = ({1'b0, id_wide} < (WIDE_W + 1)'(ID_SPACE));
   assign last_slot   = IDX_W'(live_total_ff - CNT_W'(1));
   assign full        = (live_total_ff >= CNT_W'(ID_SPACE));
   assign present     = sp_rd_ff.valid;

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.slot_index = rsp_slot_ff;
   assign rsp.live_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      live_total_in = live_total_ff;
      rsp_load      = 1'b0;
      rsp_status_in = ST_ABSENT;
      rsp_slot_in   = '0;
      sp_we         = 1'b0;
      sp_re         = 1'b0;
      sp_addr       = id_wide[IDX_W-1:0];
      sp_wdata      = '0;
      dn_we         = 1'b0;
      dn_re         = 1'b0;
      dn_addr       = last_slot;
      dn_wdata      = id_idx_ff;

      case (state_ff)
         S_CLEAR: begin
            sp_we   = 1'b1;
            sp_addr = clear_addr_ff;
            if (clear_addr_ff == IDX_W'(ID_SPACE - 1)) begin
               state_in = S_IDLE;
            end else begin
               clear_addr_in = clear_addr_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            // Read the id's sparse entry and the id in the last dense slot together.
            if (accept) begin
               sp_re    = 1'b1;
               dn_re    = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               case (op_ff)
                  OP_INSERT: begin
                     if (in_range_ff && present) begin
                        rsp_status_in = ST_FOUND;
                        rsp_slot_in   = SLOT_W'(sp_rd_ff.slot);
                     end else if (in_range_ff && !full) begin
                        sp_we         = 1'b1;
                        sp_addr       = id_idx_ff;
                        sp_wdata      = '{valid: 1'b1, slot: IDX_W'(live_total_ff)};
                        dn_we         = 1'b1;
                        dn_addr       = IDX_W'(live_total_ff);
                        dn_wdata      = id_idx_ff;
                        live_total_in = live_total_ff + CNT_W'(1);
                        rsp_status_in = ST_NEW;
                        rsp_slot_in   = SLOT_W'(live_total_ff);
                     end
                  end
                  OP_REMOVE: begin
                     if (in_range_ff && present && (live_total_ff != '0) &&
                         (CNT_W'(sp_rd_ff.slot) < live_total_ff)) begin
                        live_total_in = live_total_ff - CNT_W'(1);
                        rsp_status_in = ST_REMOVED;
                        rsp_slot_in   = SLOT_W'(sp_rd_ff.slot);
                        if (sp_rd_ff.slot != last_slot) begin
                           // Move the last dense id into the hole and repoint it;
                           // the removed id is cleared in the next cycle.
                           dn_we    = 1'b1;
                           dn_addr  = sp_rd_ff.slot;
                           dn_wdata = dn_rd_ff;
                           sp_we    = 1'b1;
                           sp_addr  = dn_rd_ff;
                           sp_wdata = '{valid: 1'b1, slot: sp_rd_ff.slot};
                           state_in = S_UNLINK;
                        end else begin
                           sp_we    = 1'b1;
                           sp_addr  = id_idx_ff;
                        end
                     end
                  end
                  default: begin
                     if (in_range_ff && present) begin
                        rsp_status_in = ST_FOUND;
                        rsp_slot_in   = SLOT_W'(sp_rd_ff.slot);
                     end
                  end
               endcase
            end
         end
         S_UNLINK: begin
            sp_we    = 1'b1;
            sp_addr  = id_idx_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sp_we) begin
         sparse_mem[sp_addr] <= sp_wdata;
      end else if (sp_re) begin
         sp_rd_ff <= sparse_mem[sp_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dn_we) begin
         dense_mem[dn_addr] <= dn_wdata;
      end else if (dn_re) begin
         dn_rd_ff <= dense_mem[dn_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         live_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         live_total_ff <= live_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req.op;
         id_idx_ff   <= id_wide[IDX_W-1:0];
         in_range_ff <= id_in_range;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_count_ff  <= COUNT_W'(live_total_in);
      end
   end

   `SSMT_ASSERT_NEXT(a_accept_to_decide, accept, state_ff == S_DECIDE,
      "accepted request did not move to the decide step")
   `SSMT_ASSERT_NEXT(a_count_step, 1'b1,
      (live_total_ff == $past(live_total_ff)) ||
      (live_total_ff == $past(live_total_ff) + CNT_W'(1)) ||
      (live_total_ff == $past(live_total_ff) - CNT_W'(1)),
      "live count moved by more than one")
   `SSMT_ASSERT_NEXT(a_new_grows, rsp_load && (rsp_status_in == ST_NEW),
      live_total_ff == $past(live_total_ff) + CNT_W'(1),
      "new insert did not grow the live count")
   `SSMT_ASSERT_NEXT(a_remove_shrinks, rsp_load && (rsp_status_in == ST_REMOVED),
      live_total_ff == $past(live_total_ff) - CNT_W'(1),
      "remove did not shrink the live count")

endmodule
